// ===== sv/pgs_packet_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// PGS packet deframer assertion macros
// Shared assertion forms for the deframer's checks.
// ----------------------------------------------------------------------------
`ifndef PGS_PACKET_DEFRAMER_DEFINES_SVH
`define PGS_PACKET_DEFRAMER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PGSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgs_packet_deframer: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PGSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgs_packet_deframer: assertion failed");

`endif

// ===== sv/pgsd_pkg.sv =====
// ----------------------------------------------------------------------------
// PGS deframer package
// Result codes, the result word and the parser status shared by the modules.
// ----------------------------------------------------------------------------
package pgsd_pkg;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_PAYLOAD = 3'd1,
      KIND_BADMARK = 3'd2,
      KIND_TRUNC   = 3'd3,
      KIND_END     = 3'd4
   } kind_type;

   localparam logic [15:0] MARKER_RESET = 16'h5047;
   localparam logic [3:0]  HDR_LAST     = 4'd12;
   localparam int          SHIFT_W      = 80;

   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] pres_time;
      logic [31:0] decode_time;
      logic [7:0]  seg_kind;
      logic [15:0] seg_length;
      logic [7:0]  payload_byte;
      logic        last_of_packet;
   } rsp_type;

   typedef struct packed {
      logic       in_payload;
      logic [3:0] hdr_count;
   } stat_type;

endpackage

// ===== sv/pgs_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// PGS packet deframer
// Splits a subtitle byte stream into header, payload, error and end results.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_data_byte, req_stream_end
//   rsp      out        rsp_valid, rsp_ready, rsp_result_kind .. rsp_last_of_packet
//   csr      in         csr_valid, csr_ready, csr_marker_word
//
// One word per cycle is accepted while the receiver does not stall the output register.
// The result appears in the output register the cycle after acceptance.
// A stalled result blocks new words only while the output register is full.
// Reset clears the framing state and sets the marker to "PG".
// ----------------------------------------------------------------------------
`include "pgs_packet_deframer_defines.svh"

module pgs_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [31:0] rsp_pres_time,
   output logic [31:0] rsp_decode_time,
   output logic [7:0]  rsp_seg_kind,
   output logic [15:0] rsp_seg_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_packet,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_marker_word
);
   import pgsd_pkg::*;

   logic [15:0] marker_ff;
   logic        accept;
   logic        res_valid;
   rsp_type     res_data;
   rsp_type     out_data;
   stat_type    status;
   logic        take_ok;
   logic        end_taken;
   logic        payload_taken;
   logic        rsp_is_stop;
   logic        rsp_is_payload;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else if (csr_valid && csr_ready) begin
         marker_ff <= csr_marker_word;
      end
   end

   assign req_ready = take_ok;
   assign accept    = req_valid && req_ready;

   pgsd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .stream_end   (req_stream_end),
      .marker_word  (marker_ff),
      .result_valid (res_valid),
      .result       (res_data),
      .status       (status)
   );

   pgsd_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_valid (res_valid),
      .load_data  (res_data),
      .take_ok    (take_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_result_kind    = out_data.result_kind;
   assign rsp_pres_time      = out_data.pres_time;
   assign rsp_decode_time    = out_data.decode_time;
   assign rsp_seg_kind       = out_data.seg_kind;
   assign rsp_seg_length     = out_data.seg_length;
   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_last_of_packet = out_data.last_of_packet;

   assign end_taken      = accept && req_stream_end;
   assign payload_taken  = accept && !req_stream_end && status.in_payload;
   assign rsp_is_stop    = rsp_result_kind inside {KIND_TRUNC, KIND_END};
   assign rsp_is_payload = (rsp_result_kind == KIND_PAYLOAD);

   `PGSD_ASSERT_SAME(a_payload_no_hdr, clock, reset, status.in_payload, status.hdr_count == 4'd0)
   `PGSD_ASSERT_NEXT(a_end_result, clock, reset, end_taken, rsp_valid && rsp_is_stop)
   `PGSD_ASSERT_NEXT(a_payload_result, clock, reset, payload_taken, rsp_valid && rsp_is_payload)

endmodule

// ===== sv/pgsd_parser.sv =====
// ----------------------------------------------------------------------------
// PGS deframer parser
// Holds the framing state and forms the result, if any, of each accepted word.
// ----------------------------------------------------------------------------
module pgsd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             stream_end,
   input  logic [15:0]      marker_word,
   output logic             result_valid,
   output pgsd_pkg::rsp_type result,
   output pgsd_pkg::stat_type status
);
   import pgsd_pkg::*;

   typedef enum logic {
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [3:0]           count_ff, count_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [15:0]          left_ff, left_in;
   logic [SHIFT_W+7:0]   full_hdr;
   logic [15:0]          left_dec;

   assign full_hdr = {shift_ff, data_byte};
   assign left_dec = left_ff - 16'd1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      result_valid = 1'b0;
      result       = '0;
      if (stream_end) begin
         result_valid = 1'b1;
         if (phase_ff == PH_PAYLOAD || count_ff != 4'd0) begin
            result.result_kind    = KIND_TRUNC;
            result.last_of_packet = 1'b1;
            phase_in              = PH_HEADER;
            count_in              = 4'd0;
         end else begin
            result.result_kind = KIND_END;
         end
      end else if (phase_ff == PH_PAYLOAD) begin
         result_valid        = 1'b1;
         result.result_kind  = KIND_PAYLOAD;
         result.payload_byte = data_byte;
         left_in             = left_dec;
         if (left_dec == 16'd0) begin
            result.last_of_packet = 1'b1;
            phase_in              = PH_HEADER;
            count_in              = 4'd0;
         end
      end else if (count_ff == 4'd0) begin
         shift_in = {{(SHIFT_W-8){1'b0}}, data_byte};
         count_in = 4'd1;
      end else if (count_ff == 4'd1) begin
         if ({shift_ff[7:0], data_byte} != marker_word) begin
            result_valid          = 1'b1;
            result.result_kind    = KIND_BADMARK;
            result.last_of_packet = 1'b1;
            count_in              = 4'd0;
         end else begin
            shift_in = '0;
            count_in = 4'd2;
         end
      end else begin
         shift_in = full_hdr[SHIFT_W-1:0];
         count_in = count_ff + 4'd1;
         if (count_ff >= HDR_LAST) begin
            result_valid          = 1'b1;
            result.result_kind    = KIND_HEADER;
            result.pres_time      = full_hdr[87:56];
            result.decode_time    = full_hdr[55:24];
            result.seg_kind       = full_hdr[23:16];
            result.seg_length     = full_hdr[15:0];
            result.last_of_packet = (full_hdr[15:0] == 16'd0);
            count_in              = 4'd0;
            left_in               = full_hdr[15:0];
            if (full_hdr[15:0] != 16'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      if (accept) begin
         shift_ff <= shift_in;
         left_ff  <= left_in;
      end
   end

   assign status.in_payload = (phase_ff == PH_PAYLOAD);
   assign status.hdr_count  = count_ff;

endmodule

// ===== sv/pgsd_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// PGS deframer result register
// One output stage that takes a new result whenever it is empty or drained.
// ----------------------------------------------------------------------------
module pgsd_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              load_valid,
   input  pgsd_pkg::rsp_type load_data,
   output logic              take_ok,
   output logic              out_valid,
   input  logic              out_ready,
   output pgsd_pkg::rsp_type out_data
);
   import pgsd_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign take_ok = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take_ok) begin
         valid_ff <= load && load_valid;
      end
      if (take_ok && load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== tb/pgs_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PGS packet deframer testbench
// Drives a byte stream of headers, payloads, bad markers, truncations and
// stream ends into the deframer under random sender gaps and receiver stalls.
// A behavioral deframer, or a directed row, gives every expected result word, checked field by
// field against the output, across several marker settings.
// ----------------------------------------------------------------------------
module pgs_packet_deframer_tb;
   import pgsd_pkg::*;

   localparam logic [3:0] HDR_TOTAL   = 4'd13;
   localparam int         DRAIN_SLACK = 8;
   localparam int         PRINT_CAP   = 100;

   typedef struct {
      logic       eos;
      logic [7:0] data;
      logic       typed;
      kind_type   kind;
      logic       last;
   } stim_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_style_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte   = 8'h00;
   logic        req_stream_end  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [31:0] rsp_pres_time;
   logic [31:0] rsp_decode_time;
   logic [7:0]  rsp_seg_kind;
   logic [15:0] rsp_seg_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_packet;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_marker_word = 16'h0000;

   // Behavioral deframer state.
   logic [15:0] marker;
   logic        in_payload;
   logic [3:0]  hdr_count;
   logic [7:0]  mark_first;
   logic [87:0] hdr_shift;
   logic [15:0] payload_left;

   rsp_type         expected_words[$];
   stim_row_type    dir_rows[$];
   int              mismatches  = 0;
   int              phase_items = 0;
   int              burst_left  = 0;
   ready_style_type stall_style = READY_ALWAYS;
   int              stall_span  = 0;

   pgs_packet_deframer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_stream_end     (req_stream_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_pres_time      (rsp_pres_time),
      .rsp_decode_time    (rsp_decode_time),
      .rsp_seg_kind       (rsp_seg_kind),
      .rsp_seg_length     (rsp_seg_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_marker_word    (csr_marker_word)
   );

   always #5 clock = ~clock;

   function automatic void clear_framing();
      in_payload   = 1'b0;
      hdr_count    = 4'd0;
      mark_first   = 8'h00;
      hdr_shift    = '0;
      payload_left = 16'd0;
   endfunction

   function automatic bit deframe_step(input logic eos, input logic [7:0] b,
                                       output rsp_type r);
      r = '0;
      if (eos) begin
         if (in_payload || hdr_count != 4'd0) begin
            clear_framing();
            r.result_kind    = KIND_TRUNC;
            r.last_of_packet = 1'b1;
         end else begin
            r.result_kind = KIND_END;
         end
         return 1'b1;
      end
      if (in_payload) begin
         payload_left   = payload_left - 16'd1;
         r.result_kind  = KIND_PAYLOAD;
         r.payload_byte = b;
         if (payload_left == 16'd0) begin
            clear_framing();
            r.last_of_packet = 1'b1;
         end
         return 1'b1;
      end
      if (hdr_count == 4'd0) begin
         mark_first = b;
         hdr_count  = 4'd1;
         return 1'b0;
      end
      if (hdr_count == 4'd1) begin
         if ({mark_first, b} != marker) begin
            clear_framing();
            r.result_kind    = KIND_BADMARK;
            r.last_of_packet = 1'b1;
            return 1'b1;
         end
         hdr_shift = '0;
         hdr_count = 4'd2;
         return 1'b0;
      end
      hdr_shift = {hdr_shift[79:0], b};
      hdr_count = hdr_count + 4'd1;
      if (hdr_count != HDR_TOTAL)
         return 1'b0;
      r.result_kind = KIND_HEADER;
      r.pres_time   = hdr_shift[87:56];
      r.decode_time = hdr_shift[55:24];
      r.seg_kind    = hdr_shift[23:16];
      r.seg_length  = hdr_shift[15:0];
      clear_framing();
      if (r.seg_length != 16'd0) begin
         in_payload   = 1'b1;
         payload_left = r.seg_length;
      end else begin
         r.last_of_packet = 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   task automatic add_row(input logic eos, input logic [7:0] data, input logic typed,
                          input kind_type kind, input logic last);
      stim_row_type row;
      row.eos   = eos;
      row.data  = data;
      row.typed = typed;
      row.kind  = kind;
      row.last  = last;
      dir_rows.push_back(row);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic eos, input logic [7:0] b, input logic typed,
                            input kind_type kind, input logic last);
      rsp_type predicted;
      rsp_type typed_word;
      bit      produces;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_stream_end <= eos;
      req_data_byte  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produces = deframe_step(eos, b, predicted);
      if (typed) begin
         typed_word                = '0;
         typed_word.result_kind    = kind;
         typed_word.last_of_packet = last;
         expected_words.push_back(typed_word);
      end else if (produces) begin
         expected_words.push_back(predicted);
      end
      phase_items++;
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_valid  <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_marker(input logic [15:0] value);
      csr_valid       <= 1'b1;
      csr_marker_word <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      marker = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_packet();
      logic [8:0]  words[$];
      logic [31:0] pts;
      logic [31:0] dts;
      logic [15:0] len;
      logic [15:0] bad;
      int          pick;
      int          cut;
      int          sel;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
         pts = $urandom();
         dts = $urandom();
         sel = $urandom_range(0, 9);
         if (sel == 0)
            len = 16'd0;
         else if (sel == 9)
            len = 16'($urandom_range(13, 64));
         else
            len = 16'($urandom_range(1, 12));
         words.push_back({1'b0, marker[15:8]});
         words.push_back({1'b0, marker[7:0]});
         for (int i = 3; i >= 0; i--) words.push_back({1'b0, pts[8*i +: 8]});
         for (int i = 3; i >= 0; i--) words.push_back({1'b0, dts[8*i +: 8]});
         words.push_back({1'b0, 8'($urandom())});
         words.push_back({1'b0, len[15:8]});
         words.push_back({1'b0, len[7:0]});
         for (int i = 0; i < len; i++) words.push_back({1'b0, 8'($urandom())});
         if (pick >= 70) begin
            cut = $urandom_range(1, words.size() - 1);
            while (words.size() > cut) void'(words.pop_back());
            words.push_back({1'b1, 8'($urandom())});
         end
      end else if (pick < 86) begin
         bad = marker ^ (16'h0001 << $urandom_range(0, 15));
         words.push_back({1'b0, bad[15:8]});
         words.push_back({1'b0, bad[7:0]});
      end else if (pick < 93) begin
         words.push_back({1'b1, 8'($urandom())});
      end else begin
         cut = $urandom_range(1, 5);
         for (int i = 0; i < cut; i++)
            words.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom())});
         words.push_back({1'b1, 8'($urandom())});
      end
      foreach (words[i])
         send_item(words[i][8], words[i][7:0], 1'b0, KIND_HEADER, 1'b0);
   endtask

   task automatic random_phase(input logic [15:0] value, input int count);
      write_marker(value);
      phase_items = 0;
      while (phase_items < count) random_packet();
      idle_sender();
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_style <= ready_style_type'($urandom_range(0, 3));
         stall_span  <= $urandom_range(16, 160);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_style)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         READY_SPARSE: begin
            rsp_ready <= ($urandom_range(0, 4) == 0);
         end
         default: begin
            rsp_ready <= (stall_span[2:0] != 3'd0);
         end
      endcase
   end

   always @(posedge clock) begin : check_word
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, kind", 32'd0, 32'(rsp_result_kind));
         end else begin
            want = expected_words.pop_front();
            if (rsp_result_kind != want.result_kind)
               report_mismatch("result_kind", 32'(want.result_kind), 32'(rsp_result_kind));
            if (rsp_pres_time != want.pres_time)
               report_mismatch("pres_time", want.pres_time, rsp_pres_time);
            if (rsp_decode_time != want.decode_time)
               report_mismatch("decode_time", want.decode_time, rsp_decode_time);
            if (rsp_seg_kind != want.seg_kind)
               report_mismatch("seg_kind", 32'(want.seg_kind), 32'(rsp_seg_kind));
            if (rsp_seg_length != want.seg_length)
               report_mismatch("seg_length", 32'(want.seg_length), 32'(rsp_seg_length));
            if (rsp_payload_byte != want.payload_byte)
               report_mismatch("payload_byte", 32'(want.payload_byte),
                               32'(rsp_payload_byte));
            if (rsp_last_of_packet != want.last_of_packet)
               report_mismatch("last_of_packet", 32'(want.last_of_packet),
                               32'(rsp_last_of_packet));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** pgs_packet_deframer: FAILED **");
      $finish;
   end

   initial begin
      marker = MARKER_RESET;
      clear_framing();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Runs with the reset marker before any write.
      add_row(1'b1, 8'h00, 1'b1, KIND_END,     1'b0);
      add_row(1'b1, 8'h00, 1'b1, KIND_END,     1'b0);
      add_row(1'b0, 8'h50, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b0, 8'h48, 1'b1, KIND_BADMARK, 1'b1);
      add_row(1'b0, 8'h50, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b1, 8'h00, 1'b1, KIND_TRUNC,   1'b1);
      add_row(1'b0, 8'h50, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b0, 8'h47, 1'b0, KIND_HEADER,  1'b0);
      for (int i = 0; i < 4; i++) add_row(1'b0, 8'hFF, 1'b0, KIND_HEADER, 1'b0);
      for (int i = 0; i < 4; i++) add_row(1'b0, 8'h00, 1'b0, KIND_HEADER, 1'b0);
      add_row(1'b0, 8'hFF, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b0, 8'hFF, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b0, 8'hFF, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b0, 8'h00, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b0, 8'hFF, 1'b0, KIND_HEADER,  1'b0);
      add_row(1'b1, 8'h00, 1'b1, KIND_TRUNC,   1'b1);
      add_row(1'b1, 8'hFF, 1'b1, KIND_END,     1'b0);
      foreach (dir_rows[i])
         send_item(dir_rows[i].eos, dir_rows[i].data, dir_rows[i].typed,
                   dir_rows[i].kind, dir_rows[i].last);
      idle_sender();
      wait_drained();

      random_phase(16'h0000, 260);
      random_phase(16'hFFFF, 260);
      random_phase(16'($urandom_range(0, 65535)), 260);
      random_phase(MARKER_RESET, 260);

      if (expected_words.size() != 0)
         report_mismatch("words still expected", 32'd0, 32'(expected_words.size()));
      if (mismatches == 0) begin
         $display("** pgs_packet_deframer: PASSED **");
      end else begin
         $display("** pgs_packet_deframer: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pgsd_pkg.sv
sv/pgsd_parser.sv
sv/pgsd_rsp_reg.sv
sv/pgs_packet_deframer.sv
tb/pgs_packet_deframer_tb.sv
